FILE: sv/clustered_light_binning_core_assert.svh
// Assertion macros shared by the clustered light binning modules.
// Each macro expects the using module to have i_clk and i_rst_n ports.
`ifndef CLUSTERED_LIGHT_BINNING_CORE_ASSERT_SVH
`define CLUSTERED_LIGHT_BINNING_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CLB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clustered light binning check failed");

// Consequent checked in the cycle after the antecedent.
`define CLB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clustered light binning check failed");

`endif

FILE: sv/clb_pkg.sv
// Shared types and default sizes for the clustered light binning core.
// No dependencies; used by clb_ctrl, clb_datapath and the top level.
package clb_pkg;

    localparam int GRID_WIDTH_DEF        = 16;
    localparam int GRID_ROWS_DEF         = 8;
    localparam int GRID_SLICES_DEF       = 16;
    localparam int SLOTS_PER_CLUSTER_DEF = 32;
    localparam int MAX_LIGHTS_DEF        = 256;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic base;
        logic cnt_rd;
        logic cnt_wr;
        logic q_rd;
        logic q_slot;
        logic sweep;
    } t_clb_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic skip;
        logic walk_last;
        logic sweep_last;
    } t_clb_status;

endpackage

FILE: sv/clb_ctrl.sv
// Controller state machine of the clustered light binning core.
// Depends on clb_pkg and clustered_light_binning_core_assert.svh.
`include "clustered_light_binning_core_assert.svh"

module clb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [1:0]           i_kind,
    input  clb_pkg::t_clb_status i_status,
    output logic                 busy,
    output logic                 o_done,
    output clb_pkg::t_clb_cmd    o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SWEEP  = 9'b000000010,
        ST_SETUP  = 9'b000000100,
        ST_BASE   = 9'b000001000,
        ST_CNT_RD = 9'b000010000,
        ST_CNT_WR = 9'b000100000,
        ST_Q_RD   = 9'b001000000,
        ST_Q_SLOT = 9'b010000000,
        ST_RESP   = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    logic            r_reply, n_reply;
    clb_pkg::t_kind  r_kind, n_kind;
    logic            accept;

    assign busy   = (r_state != ST_IDLE) && (r_state != ST_RESP);
    assign accept = start && !busy;
    assign o_done = (r_state == ST_RESP);

    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        n_kind  = r_kind;
        case (r_state)
            ST_IDLE, ST_RESP: begin
                n_state = ST_IDLE;
                if (accept) begin
                    n_kind = clb_pkg::t_kind'(i_kind);
                    case (clb_pkg::t_kind'(i_kind))
                        clb_pkg::KIND_CLEAR: begin
                            n_state = ST_SWEEP;
                            n_reply = 1'b1;
                        end
                        clb_pkg::KIND_ADD, clb_pkg::KIND_READ: begin
                            n_state = ST_SETUP;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = r_reply ? ST_RESP : ST_IDLE;
                    n_reply = 1'b0;
                end
            end
            ST_SETUP: begin
                n_state = i_status.skip ? ST_RESP : ST_BASE;
            end
            ST_BASE: begin
                n_state = (r_kind == clb_pkg::KIND_ADD) ? ST_CNT_RD : ST_Q_RD;
            end
            ST_CNT_RD: begin
                n_state = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                n_state = i_status.walk_last ? ST_RESP : ST_CNT_RD;
            end
            ST_Q_RD: begin
                n_state = ST_Q_SLOT;
            end
            ST_Q_SLOT: begin
                n_state = ST_RESP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Reset starts with a clearing pass over the fill counts, with no result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_reply <= 1'b0;
            r_kind  <= clb_pkg::KIND_NONE;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.setup  = (r_state == ST_SETUP);
        o_cmd.base   = (r_state == ST_BASE);
        o_cmd.cnt_rd = (r_state == ST_CNT_RD);
        o_cmd.cnt_wr = (r_state == ST_CNT_WR);
        o_cmd.q_rd   = (r_state == ST_Q_RD);
        o_cmd.q_slot = (r_state == ST_Q_SLOT);
        o_cmd.sweep  = (r_state == ST_SWEEP);
    end

    `CLB_ASSERT_NEXT(a_accept_progress, accept, busy || o_done)
    `CLB_ASSERT_NEXT(a_reset_sweep_silent, (r_state == ST_SWEEP) && i_status.sweep_last && !r_reply, !o_done)

endmodule

FILE: sv/clb_datapath.sv
// Datapath of the clustered light binning core: item registers, box walk,
// fill count memory and slot memory. Depends on clb_pkg and the assert header.
`include "clustered_light_binning_core_assert.svh"

module clb_datapath #(
    parameter int GRID_WIDTH        = clb_pkg::GRID_WIDTH_DEF,
    parameter int GRID_ROWS         = clb_pkg::GRID_ROWS_DEF,
    parameter int GRID_SLICES       = clb_pkg::GRID_SLICES_DEF,
    parameter int SLOTS_PER_CLUSTER = clb_pkg::SLOTS_PER_CLUSTER_DEF,
    parameter int MAX_LIGHTS        = clb_pkg::MAX_LIGHTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  clb_pkg::t_clb_cmd    i_cmd,
    input  logic [1:0]           i_kind,
    input  logic [3:0]           i_box_min_x,
    input  logic [3:0]           i_box_max_x,
    input  logic [2:0]           i_box_min_y,
    input  logic [2:0]           i_box_max_y,
    input  logic [3:0]           i_box_min_z,
    input  logic [3:0]           i_box_max_z,
    input  logic [7:0]           i_light_id,
    input  logic [3:0]           i_query_x,
    input  logic [2:0]           i_query_y,
    input  logic [3:0]           i_query_z,
    input  logic [4:0]           i_query_slot,
    output clb_pkg::t_clb_status o_status,
    output logic [7:0]           o_entry_light,
    output logic                 o_entry_valid,
    output logic [5:0]           o_cluster_fill,
    output logic [11:0]          o_cells_written,
    output logic                 o_overflow
);

    localparam int CLUSTERS    = GRID_WIDTH * GRID_ROWS * GRID_SLICES;
    localparam int STORE_DEPTH = CLUSTERS * SLOTS_PER_CLUSTER;
    localparam int SLICE_STEP  = GRID_ROWS * GRID_WIDTH;
    localparam int XW  = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int ZW  = (GRID_SLICES > 1) ? $clog2(GRID_SLICES) : 1;
    localparam int CIW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW  = $clog2(SLOTS_PER_CLUSTER + 1);
    localparam int QW  = (CW > 5) ? CW : 5;

    clb_pkg::t_kind r_kind;
    logic [XW-1:0]  r_x0, r_x1, r_qx, r_x;
    logic [YW-1:0]  r_y0, r_y1, r_qy, r_y;
    logic [ZW-1:0]  r_z0, r_z1, r_qz, r_z;
    logic [7:0]     r_id;
    logic [4:0]     r_qs;
    logic           r_q_ok;

    logic [CIW-1:0] r_mz, r_my, r_my_x0;
    logic [CIW-1:0] r_cell, r_row_base, r_slice_base, r_sweep;
    logic [SAW-1:0] r_slot_base;
    logic [CW-1:0]  r_cnt_q;
    logic [7:0]     r_slot_q;
    logic [11:0]    r_written;
    logic           r_ovf;

    logic [CW-1:0]  r_cnt_mem  [CLUSTERS];
    logic [7:0]     r_slot_mem [STORE_DEPTH];

    logic           add_skip, cnt_full, cnt_we, slot_we, read_hit;
    logic [XW-1:0]  xs;
    logic [YW-1:0]  ys;
    logic [ZW-1:0]  zs;
    logic [CIW-1:0] cnt_waddr;
    logic [CW-1:0]  cnt_wdata;
    logic [SAW-1:0] slot_waddr, slot_raddr;

    assign add_skip = (r_id >= MAX_LIGHTS) || (r_x0 > r_x1) || (r_y0 > r_y1)
                      || (r_z0 > r_z1);
    assign o_status.skip       = (r_kind == clb_pkg::KIND_ADD) ? add_skip : !r_q_ok;
    assign o_status.walk_last  = (r_x == r_x1) && (r_y == r_y1) && (r_z == r_z1);
    assign o_status.sweep_last = (r_sweep == CIW'(CLUSTERS - 1));

    assign xs = (r_kind == clb_pkg::KIND_ADD) ? r_x0 : r_qx;
    assign ys = (r_kind == clb_pkg::KIND_ADD) ? r_y0 : r_qy;
    assign zs = (r_kind == clb_pkg::KIND_ADD) ? r_z0 : r_qz;

    assign cnt_full   = (r_cnt_q >= SLOTS_PER_CLUSTER);
    assign slot_we    = i_cmd.cnt_wr && !cnt_full;
    assign cnt_we     = i_cmd.sweep || slot_we;
    assign cnt_waddr  = i_cmd.sweep ? r_sweep : r_cell;
    assign cnt_wdata  = i_cmd.sweep ? '0 : CW'(r_cnt_q + 1'b1);
    assign slot_waddr = SAW'(r_slot_base + SAW'(r_cnt_q));
    assign slot_raddr = SAW'(r_slot_base
                        + ((r_qs < SLOTS_PER_CLUSTER) ? SAW'(r_qs) : SAW'(0)));

    // Item registers; bounds are clamped to the grid as they are taken in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= clb_pkg::t_kind'(i_kind);
            r_x0 <= (i_box_min_x >= GRID_WIDTH) ? XW'(GRID_WIDTH - 1) : XW'(i_box_min_x);
            r_x1 <= (i_box_max_x >= GRID_WIDTH) ? XW'(GRID_WIDTH - 1) : XW'(i_box_max_x);
            r_y0 <= (i_box_min_y >= GRID_ROWS) ? YW'(GRID_ROWS - 1) : YW'(i_box_min_y);
            r_y1 <= (i_box_max_y >= GRID_ROWS) ? YW'(GRID_ROWS - 1) : YW'(i_box_max_y);
            r_z0 <= (i_box_min_z >= GRID_SLICES) ? ZW'(GRID_SLICES - 1) : ZW'(i_box_min_z);
            r_z1 <= (i_box_max_z >= GRID_SLICES) ? ZW'(GRID_SLICES - 1) : ZW'(i_box_max_z);
            r_id   <= i_light_id;
            r_qx   <= XW'(i_query_x);
            r_qy   <= YW'(i_query_y);
            r_qz   <= ZW'(i_query_z);
            r_qs   <= i_query_slot;
            r_q_ok <= (i_query_x < GRID_WIDTH) && (i_query_y < GRID_ROWS)
                      && (i_query_z < GRID_SLICES);
        end
    end

    // Cluster addressing and the slice, row, column walk over the box.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_mz <= CIW'(int'(zs) * SLICE_STEP);
            r_my <= CIW'(int'(ys) * GRID_WIDTH);
        end
        if (i_cmd.base) begin
            r_cell       <= CIW'(r_mz + r_my + CIW'(xs));
            r_row_base   <= CIW'(r_mz + r_my);
            r_slice_base <= r_mz;
            r_my_x0      <= CIW'(r_my + CIW'(r_x0));
            r_x <= r_x0;
            r_y <= r_y0;
            r_z <= r_z0;
        end
        if (i_cmd.cnt_rd || i_cmd.q_rd) begin
            r_slot_base <= SAW'(int'(r_cell) * SLOTS_PER_CLUSTER);
        end
        if (i_cmd.cnt_wr && !o_status.walk_last) begin
            if (r_x != r_x1) begin
                r_x    <= XW'(r_x + 1'b1);
                r_cell <= CIW'(r_cell + 1'b1);
            end else if (r_y != r_y1) begin
                r_x        <= r_x0;
                r_y        <= YW'(r_y + 1'b1);
                r_row_base <= CIW'(r_row_base + CIW'(GRID_WIDTH));
                r_cell     <= CIW'(r_row_base + CIW'(GRID_WIDTH) + CIW'(r_x0));
            end else begin
                r_x          <= r_x0;
                r_y          <= r_y0;
                r_z          <= ZW'(r_z + 1'b1);
                r_slice_base <= CIW'(r_slice_base + CIW'(SLICE_STEP));
                r_row_base   <= CIW'(r_slice_base + CIW'(SLICE_STEP) + r_my);
                r_cell       <= CIW'(r_slice_base + CIW'(SLICE_STEP) + r_my_x0);
            end
        end
    end

    // Sweep pointer and add totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep   <= '0;
            r_written <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_sweep   <= '0;
                r_written <= '0;
                r_ovf     <= 1'b0;
            end
            if (i_cmd.sweep) begin
                r_sweep <= o_status.sweep_last ? '0 : CIW'(r_sweep + 1'b1);
            end
            if (slot_we) begin
                r_written <= 12'(r_written + 1'b1);
            end
            if (i_cmd.cnt_wr && cnt_full) begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (i_cmd.cnt_rd || i_cmd.q_rd) begin
            r_cnt_q <= r_cnt_mem[r_cell];
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= r_id;
        end
        if (i_cmd.q_slot) begin
            r_slot_q <= r_slot_mem[slot_raddr];
        end
    end

    assign read_hit        = (r_kind == clb_pkg::KIND_READ) && r_q_ok;
    assign o_entry_valid   = read_hit && (QW'(r_qs) < QW'(r_cnt_q));
    assign o_entry_light   = o_entry_valid ? r_slot_q : 8'd0;
    assign o_cluster_fill  = read_hit ? 6'(r_cnt_q) : 6'd0;
    assign o_cells_written = (r_kind == clb_pkg::KIND_ADD) ? r_written : 12'd0;
    assign o_overflow      = (r_kind == clb_pkg::KIND_ADD) && r_ovf;

    `CLB_ASSERT_NOW(a_write_after_read, i_cmd.cnt_wr, $past(i_cmd.cnt_rd))
    `CLB_ASSERT_NOW(a_count_in_range, i_cmd.cnt_wr, r_cnt_q <= SLOTS_PER_CLUSTER)

endmodule

FILE: sv/clustered_light_binning_core.sv
// Top level of the clustered light binning core: controller plus datapath.
// Depends on clb_pkg, clb_ctrl and clb_datapath.
//
//  Channel   Handshake            Payload
//  --------  -------------------  ---------------------------------------------
//  item in   start, busy          i_kind, i_box_*, i_light_id, i_query_*
//  result    o_done (one cycle)   o_entry_light, o_entry_valid, o_cluster_fill,
//                                 o_cells_written, o_overflow
//
// A transaction is taken when start is high and busy is low; the result cycle
// already accepts the next item. Add: setup, base, then per cell a count read
// and, unless full, a count write. Read: setup, base, count and slot reads.
// Clear: the fill count of every cluster (2048 by default) is zeroed. Empty
// boxes, rejected lights and reads outside the grid answer from setup, an
// unknown kind at once. After reset a clearing pass over all clusters holds busy
// high. The receiver cannot stall: o_done marks each result for exactly one cycle.

module clustered_light_binning_core #(
    parameter int GRID_WIDTH        = clb_pkg::GRID_WIDTH_DEF,
    parameter int GRID_ROWS         = clb_pkg::GRID_ROWS_DEF,
    parameter int GRID_SLICES       = clb_pkg::GRID_SLICES_DEF,
    parameter int SLOTS_PER_CLUSTER = clb_pkg::SLOTS_PER_CLUSTER_DEF,
    parameter int MAX_LIGHTS        = clb_pkg::MAX_LIGHTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_box_min_x,
    input  logic [3:0]  i_box_max_x,
    input  logic [2:0]  i_box_min_y,
    input  logic [2:0]  i_box_max_y,
    input  logic [3:0]  i_box_min_z,
    input  logic [3:0]  i_box_max_z,
    input  logic [7:0]  i_light_id,
    input  logic [3:0]  i_query_x,
    input  logic [2:0]  i_query_y,
    input  logic [3:0]  i_query_z,
    input  logic [4:0]  i_query_slot,
    output logic        o_done,
    output logic [7:0]  o_entry_light,
    output logic        o_entry_valid,
    output logic [5:0]  o_cluster_fill,
    output logic [11:0] o_cells_written,
    output logic        o_overflow
);

    clb_pkg::t_clb_cmd    cmd;
    clb_pkg::t_clb_status status;

    clb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .busy     (busy),
        .o_done   (o_done),
        .o_cmd    (cmd)
    );

    clb_datapath #(
        .GRID_WIDTH        (GRID_WIDTH),
        .GRID_ROWS         (GRID_ROWS),
        .GRID_SLICES       (GRID_SLICES),
        .SLOTS_PER_CLUSTER (SLOTS_PER_CLUSTER),
        .MAX_LIGHTS        (MAX_LIGHTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (i_kind),
        .i_box_min_x     (i_box_min_x),
        .i_box_max_x     (i_box_max_x),
        .i_box_min_y     (i_box_min_y),
        .i_box_max_y     (i_box_max_y),
        .i_box_min_z     (i_box_min_z),
        .i_box_max_z     (i_box_max_z),
        .i_light_id      (i_light_id),
        .i_query_x       (i_query_x),
        .i_query_y       (i_query_y),
        .i_query_z       (i_query_z),
        .i_query_slot    (i_query_slot),
        .o_status        (status),
        .o_entry_light   (o_entry_light),
        .o_entry_valid   (o_entry_valid),
        .o_cluster_fill  (o_cluster_fill),
        .o_cells_written (o_cells_written),
        .o_overflow      (o_overflow)
    );

endmodule

FILE: test/tb_clustered_light_binning_core.sv
// Self-checking testbench for clustered_light_binning_core: clears, adds over cell boxes
// and slot reads, checked against an in-bench model of the cluster grid.
// Depends on clb_pkg and the RTL of the core.
module tb_clustered_light_binning_core;

    localparam int GRID_W       = clb_pkg::GRID_WIDTH_DEF;
    localparam int GRID_H       = clb_pkg::GRID_ROWS_DEF;
    localparam int GRID_D       = clb_pkg::GRID_SLICES_DEF;
    localparam int SLOTS        = clb_pkg::SLOTS_PER_CLUSTER_DEF;
    localparam int LIGHT_LIMIT  = clb_pkg::MAX_LIGHTS_DEF;
    localparam int CLUSTERS     = GRID_W * GRID_H * GRID_D;
    localparam int TOTAL_ITEMS  = 1150;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        clb_pkg::t_kind kind;
        logic [3:0]     min_x;
        logic [3:0]     max_x;
        logic [2:0]     min_y;
        logic [2:0]     max_y;
        logic [3:0]     min_z;
        logic [3:0]     max_z;
        logic [7:0]     light;
        logic [3:0]     qx;
        logic [2:0]     qy;
        logic [3:0]     qz;
        logic [4:0]     qslot;
    } t_light_cmd;

    typedef struct packed {
        logic [7:0]  entry_light;
        logic        entry_valid;
        logic [5:0]  cluster_fill;
        logic [11:0] cells_written;
        logic        overflow;
    } t_bin_answer;

    // Keeps its own copy of the cluster grid and the answers still owed by the core.
    class cluster_scoreboard;
        int unsigned fill_count [CLUSTERS];
        bit [7:0]    cluster_slots [CLUSTERS][SLOTS];
        t_bin_answer answer_q [$];
        int unsigned error_count;

        function new();
            foreach (fill_count[i]) fill_count[i] = 0;
            error_count = 0;
        endfunction

        function int clamp_to(int v, int size);
            return (v >= size) ? size - 1 : v;
        endfunction

        function void bin_item(t_light_cmd c);
            t_bin_answer r;
            int x0, x1, y0, y1, z0, z1, x, y, z, cl;
            r = '0;
            case (c.kind)
                clb_pkg::KIND_CLEAR: begin
                    foreach (fill_count[i]) fill_count[i] = 0;
                end
                clb_pkg::KIND_ADD: begin
                    x0 = clamp_to(c.min_x, GRID_W);
                    x1 = clamp_to(c.max_x, GRID_W);
                    y0 = clamp_to(c.min_y, GRID_H);
                    y1 = clamp_to(c.max_y, GRID_H);
                    z0 = clamp_to(c.min_z, GRID_D);
                    z1 = clamp_to(c.max_z, GRID_D);
                    if (c.light < LIGHT_LIMIT && x0 <= x1 && y0 <= y1 && z0 <= z1) begin
                        for (z = z0; z <= z1; z++) begin
                            for (y = y0; y <= y1; y++) begin
                                for (x = x0; x <= x1; x++) begin
                                    cl = (z * GRID_H + y) * GRID_W + x;
                                    if (fill_count[cl] < SLOTS) begin
                                        cluster_slots[cl][fill_count[cl]] = c.light;
                                        fill_count[cl]++;
                                        r.cells_written = r.cells_written + 1'b1;
                                    end else begin
                                        r.overflow = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                clb_pkg::KIND_READ: begin
                    if (c.qx < GRID_W && c.qy < GRID_H && c.qz < GRID_D) begin
                        cl = (c.qz * GRID_H + c.qy) * GRID_W + c.qx;
                        r.cluster_fill = 6'(fill_count[cl]);
                        if (c.qslot < fill_count[cl] && c.qslot < SLOTS) begin
                            r.entry_light = cluster_slots[cl][c.qslot];
                            r.entry_valid = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            answer_q.push_back(r);
        endfunction

        function void check_result(t_bin_answer got);
            t_bin_answer want;
            if (answer_q.size() == 0) begin
                $error("result with no transaction pending: cells_written %0d",
                       got.cells_written);
                error_count++;
                return;
            end
            want = answer_q.pop_front();
            if (got.entry_light !== want.entry_light) begin
                $error("entry_light: expected %0d, actual %0d", want.entry_light, got.entry_light);
                error_count++;
            end
            if (got.entry_valid !== want.entry_valid) begin
                $error("entry_valid: expected %0d, actual %0d", want.entry_valid, got.entry_valid);
                error_count++;
            end
            if (got.cluster_fill !== want.cluster_fill) begin
                $error("cluster_fill: expected %0d, actual %0d",
                       want.cluster_fill, got.cluster_fill);
                error_count++;
            end
            if (got.cells_written !== want.cells_written) begin
                $error("cells_written: expected %0d, actual %0d",
                       want.cells_written, got.cells_written);
                error_count++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                error_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [3:0]  i_box_min_x;
    logic [3:0]  i_box_max_x;
    logic [2:0]  i_box_min_y;
    logic [2:0]  i_box_max_y;
    logic [3:0]  i_box_min_z;
    logic [3:0]  i_box_max_z;
    logic [7:0]  i_light_id;
    logic [3:0]  i_query_x;
    logic [2:0]  i_query_y;
    logic [3:0]  i_query_z;
    logic [4:0]  i_query_slot;
    logic        o_done;
    logic [7:0]  o_entry_light;
    logic        o_entry_valid;
    logic [5:0]  o_cluster_fill;
    logic [11:0] o_cells_written;
    logic        o_overflow;

    cluster_scoreboard sb;
    int unsigned       items_sent;
    int unsigned       burst_left;
    int unsigned       cycle_count;

    clustered_light_binning_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_box_min_x    (i_box_min_x),
        .i_box_max_x    (i_box_max_x),
        .i_box_min_y    (i_box_min_y),
        .i_box_max_y    (i_box_max_y),
        .i_box_min_z    (i_box_min_z),
        .i_box_max_z    (i_box_max_z),
        .i_light_id     (i_light_id),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_query_z      (i_query_z),
        .i_query_slot   (i_query_slot),
        .o_done         (o_done),
        .o_entry_light  (o_entry_light),
        .o_entry_valid  (o_entry_valid),
        .o_cluster_fill (o_cluster_fill),
        .o_cells_written(o_cells_written),
        .o_overflow     (o_overflow)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_bin_answer got;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            got.entry_light   = o_entry_light;
            got.entry_valid   = o_entry_valid;
            got.cluster_fill  = o_cluster_fill;
            got.cells_written = o_cells_written;
            got.overflow      = o_overflow;
            sb.check_result(got);
        end
    end

    // Every field gets a random value so that don't-care inputs are exercised too.
    function automatic t_light_cmd random_fields();
        t_light_cmd c;
        c.kind  = clb_pkg::t_kind'($urandom_range(0, 3));
        c.min_x = 4'($urandom);
        c.max_x = 4'($urandom);
        c.min_y = 3'($urandom);
        c.max_y = 3'($urandom);
        c.min_z = 4'($urandom);
        c.max_z = 4'($urandom);
        c.light = 8'($urandom);
        c.qx    = 4'($urandom);
        c.qy    = 3'($urandom);
        c.qz    = 4'($urandom);
        c.qslot = 5'($urandom);
        return c;
    endfunction

    function automatic t_light_cmd make_add(int x0, int x1, int y0, int y1, int z0, int z1,
                                            int id);
        t_light_cmd c;
        c       = random_fields();
        c.kind  = clb_pkg::KIND_ADD;
        c.min_x = 4'(x0);
        c.max_x = 4'(x1);
        c.min_y = 3'(y0);
        c.max_y = 3'(y1);
        c.min_z = 4'(z0);
        c.max_z = 4'(z1);
        c.light = 8'(id);
        return c;
    endfunction

    function automatic t_light_cmd make_read(int x, int y, int z, int slot);
        t_light_cmd c;
        c       = random_fields();
        c.kind  = clb_pkg::KIND_READ;
        c.qx    = 4'(x);
        c.qy    = 3'(y);
        c.qz    = 4'(z);
        c.qslot = 5'(slot);
        return c;
    endfunction

    function automatic t_light_cmd make_kind(clb_pkg::t_kind k);
        t_light_cmd c;
        c      = random_fields();
        c.kind = k;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(t_light_cmd c);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                start = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_kind       = c.kind;
        i_box_min_x  = c.min_x;
        i_box_max_x  = c.max_x;
        i_box_min_y  = c.min_y;
        i_box_max_y  = c.max_y;
        i_box_min_z  = c.min_z;
        i_box_max_z  = c.max_z;
        i_light_id   = c.light;
        i_query_x    = c.qx;
        i_query_y    = c.qy;
        i_query_z    = c.qz;
        i_query_slot = c.qslot;
        start        = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.bin_item(c);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (sb.answer_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_light_cmd  c;
        int unsigned hx0, hx1, hy0, hy1, hz0, hz1;
        int unsigned roll, pick;

        sb           = new();
        items_sent   = 0;
        burst_left   = 0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = '0;
        i_box_min_x  = '0;
        i_box_max_x  = '0;
        i_box_min_y  = '0;
        i_box_max_y  = '0;
        i_box_min_z  = '0;
        i_box_max_z  = '0;
        i_light_id   = '0;
        i_query_x    = '0;
        i_query_y    = '0;
        i_query_z    = '0;
        i_query_slot = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. The first transaction waits out the clearing pass after reset.
        send_item(make_read(0, 0, 0, 0));
        send_item(make_kind(clb_pkg::KIND_NONE));
        send_item(make_add(0, 15, 0, 7, 0, 15, 255));
        send_item(make_read(15, 7, 15, 0));
        send_item(make_read(15, 7, 15, 31));
        send_item(make_read(0, 0, 0, 0));
        send_item(make_add(5, 4, 0, 7, 0, 15, 17));
        send_item(make_add(0, 15, 3, 2, 0, 15, 18));
        send_item(make_add(0, 15, 0, 7, 15, 0, 19));
        send_item(make_add(0, 0, 0, 0, 0, 0, 0));
        send_item(make_read(0, 0, 0, 1));
        send_item(make_read(0, 0, 0, 2));
        send_item(make_add(15, 15, 7, 7, 15, 15, 170));
        send_item(make_read(15, 7, 15, 1));
        send_item(make_kind(clb_pkg::KIND_CLEAR));
        send_item(make_read(15, 7, 15, 0));
        send_item(make_read(0, 0, 0, 0));
        wait_drained();

        // Random phases. Each one focuses most adds on a small region of clusters so that
        // those clusters fill up and later adds run into full clusters.
        while (items_sent < TOTAL_ITEMS) begin
            hx0 = $urandom_range(0, 13);
            hx1 = hx0 + $urandom_range(0, 2);
            hy0 = $urandom_range(0, 6);
            hy1 = hy0 + $urandom_range(0, 1);
            hz0 = $urandom_range(0, 13);
            hz1 = hz0 + $urandom_range(0, 2);
            send_item(make_kind(clb_pkg::KIND_CLEAR));
            repeat ($urandom_range(100, 180)) begin
                roll = $urandom_range(0, 999);
                pick = $urandom_range(0, 99);
                if (roll < 520) begin
                    if (pick < 65) begin
                        c = make_add(hx0, hx1, hy0, hy1, hz0, hz1, $urandom);
                    end else if (pick < 80) begin
                        // Sub-box of the region; inverted bounds give empty boxes.
                        c = make_add($urandom_range(hx0, hx1), $urandom_range(hx0, hx1),
                                     $urandom_range(hy0, hy1), $urandom_range(hy0, hy1),
                                     $urandom_range(hz0, hz1), $urandom_range(hz0, hz1),
                                     $urandom);
                    end else if (pick < 92) begin
                        c = make_kind(clb_pkg::KIND_ADD);
                        c.max_x = (c.min_x > 12) ? 4'd15 : c.min_x + 4'($urandom_range(0, 3));
                        c.max_y = (c.min_y > 4) ? 3'd7 : c.min_y + 3'($urandom_range(0, 3));
                        c.max_z = (c.min_z > 12) ? 4'd15 : c.min_z + 4'($urandom_range(0, 3));
                    end else begin
                        c = make_kind(clb_pkg::KIND_ADD);
                    end
                end else if (roll < 940) begin
                    if (pick < 70) begin
                        c = make_read($urandom_range(hx0, hx1), $urandom_range(hy0, hy1),
                                      $urandom_range(hz0, hz1), $urandom_range(0, 31));
                    end else begin
                        c = make_kind(clb_pkg::KIND_READ);
                    end
                end else if (roll < 990) begin
                    c = make_kind(clb_pkg::KIND_NONE);
                end else begin
                    c = make_kind(clb_pkg::KIND_CLEAR);
                end
                if (items_sent < TOTAL_ITEMS) begin
                    send_item(c);
                end
            end
            if ($urandom_range(0, 2) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.error_count == 0 && sb.answer_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: clustered_light_binning_core.f
+incdir+sv
sv/clb_pkg.sv
sv/clb_ctrl.sv
sv/clb_datapath.sv
sv/clustered_light_binning_core.sv
test/tb_clustered_light_binning_core.sv
